// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion helpers
// expects signals named clock and reset in the module that uses them
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/rtp_pkg.sv =====
// ----------------------------------------------------------------------------
// rtp_pkg
// constants and tables for the rectangular-to-polar cordic
// ----------------------------------------------------------------------------
package rtp_pkg;

   // extra fraction bits on x and y
   localparam int GUARD = 6;
   // angle accumulator width, q30 radians with headroom past pi
   localparam int ZW = 34;
   localparam int TABLE_W = 30;

   localparam longint PI_Q30      = 64'sd3373259426;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;

   // elementary angles atan(2^-i) in q30
   function automatic logic [TABLE_W-1:0] atan_q30(input logic [4:0] idx);
      logic [TABLE_W-1:0] v;
      unique case (idx)
         5'd0:  v = 30'h3243F6A8;
         5'd1:  v = 30'h1DAC6705;
         5'd2:  v = 30'h0FADBAFC;
         5'd3:  v = 30'h07F56EA6;
         5'd4:  v = 30'h03FEAB76;
         5'd5:  v = 30'h01FFD55B;
         5'd6:  v = 30'h00FFFAAA;
         5'd7:  v = 30'h007FFF55;
         5'd8:  v = 30'h003FFFEA;
         5'd9:  v = 30'h001FFFFD;
         5'd10: v = 30'h000FFFFF;
         5'd11: v = 30'h0007FFFF;
         5'd12: v = 30'h0003FFFF;
         5'd13: v = 30'h0001FFFF;
         5'd14: v = 30'h0000FFFF;
         5'd15: v = 30'h00007FFF;
         5'd16: v = 30'h00003FFF;
         5'd17: v = 30'h00001FFF;
         5'd18: v = 30'h00000FFF;
         5'd19: v = 30'h000007FF;
         5'd20: v = 30'h000003FF;
         5'd21: v = 30'h000001FF;
         5'd22: v = 30'h000000FF;
         5'd23: v = 30'h0000007F;
         5'd24: v = 30'h0000003F;
         5'd25: v = 30'h0000001F;
         5'd26: v = 30'h0000000F;
         5'd27: v = 30'h00000008;
         5'd28: v = 30'h00000004;
         5'd29: v = 30'h00000002;
         5'd30: v = 30'h00000001;
         5'd31: v = 30'h00000000;
      endcase
      return v;
   endfunction

   // q30 gain correction, index = stages - 8, limit value from 16 stages on
   function automatic logic [TABLE_W-1:0] gain_q30(input logic [3:0] idx);
      logic [TABLE_W-1:0] v;
      unique case (idx)
         4'd0:    v = 30'd652039507;
         4'd1:    v = 30'd652034532;
         4'd2:    v = 30'd652033289;
         4'd3:    v = 30'd652032978;
         4'd4:    v = 30'd652032900;
         4'd5:    v = 30'd652032881;
         4'd6:    v = 30'd652032876;
         4'd7:    v = 30'd652032875;
         default: v = 30'd652032874;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/rect_to_polar_converter_unit.sv =====
// pipeline: one pre-rotation stage, one stage per cordic micro-rotation,
// then gain multiply, rounding add and output register
// throughput: one beat per cycle unless stalled by rsp_ready, set by the fully unrolled rotation stages
// reset: synchronous, clears all stage valid bits; data registers are not reset
// ----------------------------------------------------------------------------
// rect_to_polar_converter_unit
// pipelined cordic in vectoring mode: (re, im) -> (radius, angle)
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rect_to_polar_converter_unit #(
   parameter int DATA_WIDTH = 16,
   parameter int ITERATIONS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [DATA_WIDTH-1:0] req_real_part,
   input  logic signed [DATA_WIDTH-1:0] req_imag_part,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic        [DATA_WIDTH-1:0] rsp_radius,
   output logic signed [DATA_WIDTH-1:0] rsp_angle
);

   localparam int DW = DATA_WIDTH;
   localparam int NI = ITERATIONS;
   localparam int G  = rtp_pkg::GUARD;
   localparam int ZW = rtp_pkg::ZW;
   localparam int XW = DW + G + 3;
   localparam int NS = NI + 4;
   localparam int MS = NI + 1;
   localparam int SS = NI + 2;
   localparam int PW = XW - 1 + 15;
   localparam int TW = ((PW > 36) ? PW : 36) + 1;
   localparam int SW = PW + 1;
   localparam int ASHIFT = 33 - DW;
   localparam int GI = (NI > 16) ? 8 : NI - 8;

   localparam logic [29:0] GAIN = rtp_pkg::gain_q30(4'(GI));
   localparam logic [14:0] KH   = GAIN[29:15];
   localparam logic [14:0] KL   = GAIN[14:0];
   localparam logic [TW-1:0] ROUND_T = TW'(64'd1 << 35);

   localparam longint PI_OUT = (rtp_pkg::PI_Q30 + (64'sd1 <<< (ASHIFT - 1))) >>> ASHIFT;
   localparam longint HP_OUT =
      (rtp_pkg::HALF_PI_Q30 + (64'sd1 <<< (ASHIFT - 1))) >>> ASHIFT;
   localparam longint NHP_OUT =
      ((-rtp_pkg::HALF_PI_Q30) + (64'sd1 <<< (ASHIFT - 1))) >>> ASHIFT;

   localparam logic signed [DW-1:0] PI_ANG  = DW'(PI_OUT);
   localparam logic signed [DW-1:0] HP_ANG  = DW'(HP_OUT);
   localparam logic signed [DW-1:0] NHP_ANG = DW'(NHP_OUT);
   localparam logic signed [ZW:0]   PI_CMP  = (ZW + 1)'(PI_OUT);
   localparam logic signed [ZW:0]   NPI_CMP = (ZW + 1)'(-PI_OUT);
   localparam logic signed [ZW:0]   ZRND    = (ZW + 1)'(64'sd1 <<< (ASHIFT - 1));
   localparam logic signed [ZW-1:0] HALF_Z  = ZW'(rtp_pkg::HALF_PI_Q30);

   // ------------------------------------------------------------------
   // flow control: a stage loads when it or anything after it has room
   // ------------------------------------------------------------------
   logic [NS-1:0] vld_ff;
   logic [NS-1:0] vld_in;
   logic [NS-1:0] ld;

   for (genvar s = 0; s < NS; s++) begin : g_ld
      assign ld[s] = rsp_ready | ~(&vld_ff[NS-1:s]);
   end

   assign vld_in    = {vld_ff[NS-2:0], req_valid};
   // no beat is taken while reset is held
   assign req_ready = ld[0] & ~reset;
   assign rsp_valid = vld_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= (vld_in & ld) | (vld_ff & ~ld);
      end
   end

   // ------------------------------------------------------------------
   // stage 0: special cases and quadrant pre-rotation
   // ------------------------------------------------------------------
   logic signed [DW:0]    re_x, im_x, pre_x, pre_y;
   logic signed [ZW-1:0]  pre_z;
   logic                  re_zero, im_zero;
   logic                  spec_in;
   logic        [DW-1:0]  srad_in;
   logic signed [DW-1:0]  sang_in;
   logic        [DW-1:0]  re_abs, im_abs;

   assign re_x    = {req_real_part[DW-1], req_real_part};
   assign im_x    = {req_imag_part[DW-1], req_imag_part};
   assign re_zero = (req_real_part == '0);
   assign im_zero = (req_imag_part == '0);
   assign spec_in = re_zero | im_zero;
   assign re_abs  = req_real_part[DW-1] ? DW'(-re_x) : DW'(re_x);
   assign im_abs  = req_imag_part[DW-1] ? DW'(-im_x) : DW'(im_x);

   always_comb begin
      priority if (re_zero && im_zero) begin
         srad_in = '0;
         sang_in = '0;
      end else if (im_zero) begin
         srad_in = re_abs;
         sang_in = req_real_part[DW-1] ? PI_ANG : '0;
      end else begin
         srad_in = im_abs;
         sang_in = req_imag_part[DW-1] ? NHP_ANG : HP_ANG;
      end
   end

   always_comb begin
      priority if (!req_real_part[DW-1]) begin
         pre_x = re_x;
         pre_y = im_x;
         pre_z = '0;
      end else if (!req_imag_part[DW-1]) begin
         pre_x = im_x;
         pre_y = -re_x;
         pre_z = HALF_Z;
      end else begin
         pre_x = -im_x;
         pre_y = re_x;
         pre_z = -HALF_Z;
      end
   end

   logic signed [XW-1:0] x_ff [0:NI];
   logic signed [XW-1:0] y_ff [0:NI];
   logic signed [ZW-1:0] z_ff [0:NI];
   logic                 spec_ff [0:SS];
   logic        [DW-1:0] srad_ff [0:SS];
   logic signed [DW-1:0] sang_ff [0:SS];

   always_ff @(posedge clock) begin
      if (ld[0]) begin
         x_ff[0]    <= {{(XW-DW-1-G){pre_x[DW]}}, pre_x, {G{1'b0}}};
         y_ff[0]    <= {{(XW-DW-1-G){pre_y[DW]}}, pre_y, {G{1'b0}}};
         z_ff[0]    <= pre_z;
         spec_ff[0] <= spec_in;
         srad_ff[0] <= srad_in;
         sang_ff[0] <= sang_in;
      end
   end

   // special-case results ride alongside the datapath
   for (genvar s = 1; s <= SS; s++) begin : g_spec
      always_ff @(posedge clock) begin
         if (ld[s]) begin
            spec_ff[s] <= spec_ff[s-1];
            srad_ff[s] <= srad_ff[s-1];
            sang_ff[s] <= sang_ff[s-1];
         end
      end
   end

   // ------------------------------------------------------------------
   // micro-rotation stages, one per iteration
   // ------------------------------------------------------------------
   for (genvar i = 0; i < NI; i++) begin : g_rot
      localparam logic signed [ZW-1:0] ATAN_I = ZW'(rtp_pkg::atan_q30(5'(i)));
      logic signed [XW-1:0] dx, dy, x_in, y_in;
      logic signed [ZW-1:0] z_in;

      assign dx = y_ff[i] >>> i;
      assign dy = x_ff[i] >>> i;

      always_comb begin
         if (y_ff[i][XW-1]) begin
            x_in = x_ff[i] - dx;
            y_in = y_ff[i] + dy;
            z_in = z_ff[i] - ATAN_I;
         end else begin
            x_in = x_ff[i] + dx;
            y_in = y_ff[i] - dy;
            z_in = z_ff[i] + ATAN_I;
         end
      end

      always_ff @(posedge clock) begin
         if (ld[i+1]) begin
            x_ff[i+1] <= x_in;
            y_ff[i+1] <= y_in;
            z_ff[i+1] <= z_in;
         end
      end
   end

   // ------------------------------------------------------------------
   // gain multiply (split in two partial products) and angle rounding
   // ------------------------------------------------------------------
   logic        [XW-2:0] mag;
   logic                 pos_in;
   logic        [PW-1:0] hi_in, lo_in;
   logic signed [ZW:0]   zs, zr;
   logic signed [DW-1:0] ang_in;

   assign mag    = x_ff[NI][XW-2:0];
   assign pos_in = !x_ff[NI][XW-1] && (mag != '0);
   assign hi_in  = PW'(mag) * PW'(KH);
   assign lo_in  = PW'(mag) * PW'(KL);
   assign zs     = {z_ff[NI][ZW-1], z_ff[NI]} + ZRND;
   assign zr     = zs >>> ASHIFT;

   always_comb begin
      priority if (zr > PI_CMP) begin
         ang_in = PI_ANG;
      end else if (zr < NPI_CMP) begin
         ang_in = -PI_ANG;
      end else begin
         ang_in = zr[DW-1:0];
      end
   end

   logic        [PW-1:0] hi_ff, lo_ff;
   logic                 pos_ff;
   logic signed [DW-1:0] ang_ff;

   always_ff @(posedge clock) begin
      if (ld[MS]) begin
         hi_ff  <= hi_in;
         lo_ff  <= lo_in;
         pos_ff <= pos_in;
         ang_ff <= ang_in;
      end
   end

   // rounding add on the low partial product
   logic        [TW-1:0] t_in;
   logic        [TW-1:0] t_ff;
   logic        [PW-1:0] hi2_ff;
   logic                 pos2_ff;
   logic signed [DW-1:0] ang2_ff;

   assign t_in = TW'(lo_ff) + ROUND_T;

   always_ff @(posedge clock) begin
      if (ld[SS]) begin
         t_ff    <= t_in;
         hi2_ff  <= hi_ff;
         pos2_ff <= pos_ff;
         ang2_ff <= ang_ff;
      end
   end

   // ------------------------------------------------------------------
   // output stage: combine partials, saturate, pick special result
   // ------------------------------------------------------------------
   logic        [SW-1:0]    sum;
   logic        [SW-22:0]   rad_full;
   logic        [DW-1:0]    rad_in;
   logic signed [DW-1:0]    angle_in;
   logic        [DW-1:0]    rad_ff;
   logic signed [DW-1:0]    angle_ff;

   assign sum      = SW'(hi2_ff) + SW'(t_ff >> 15);
   assign rad_full = sum[SW-1:21];

   always_comb begin
      priority if (spec_ff[SS]) begin
         rad_in   = srad_ff[SS];
         angle_in = sang_ff[SS];
      end else if (!pos2_ff) begin
         rad_in   = '0;
         angle_in = ang2_ff;
      end else if (|rad_full[SW-22:DW]) begin
         rad_in   = '1;
         angle_in = ang2_ff;
      end else begin
         rad_in   = rad_full[DW-1:0];
         angle_in = ang2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ld[NS-1]) begin
         rad_ff   <= rad_in;
         angle_ff <= angle_in;
      end
   end

   assign rsp_radius = rad_ff;
   assign rsp_angle  = angle_ff;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   `ASSERT_IMPLIES(a_ready_when_room, !(&vld_ff), req_ready)
   `ASSERT_NEXT(a_accept_lands, req_valid && req_ready, vld_ff[0])
   `ASSERT_IMPLIES(a_angle_range, rsp_valid, (rsp_angle <= PI_ANG) && (rsp_angle >= -PI_ANG))
   `ASSERT_IMPLIES(a_zero_radius, rsp_valid && (rsp_radius == '0), rsp_angle == '0)

endmodule
